/* sv/iscc_pkg.sv */
// ----------------------------------------------------------------------------
// iscc_pkg
// Shared widths, codes and reset values for the integral speed controller.
// ----------------------------------------------------------------------------
package iscc_pkg;

  localparam int SpeedBits = 16;
  localparam int GainW     = 4;
  localparam int LimW      = 10;
  localparam int IntW      = 11;
  localparam int ModeW     = 2;
  localparam int MarkW     = 2;
  localparam int CfgIdxW   = 2;

  localparam int DiffW     = SpeedBits + 1;
  localparam int ProdW     = DiffW + GainW;
  localparam int AccW      = ProdW + 1;

  localparam int InDataW   = ((2 * SpeedBits + 7) / 8) * 8;
  localparam int OutDataW  = ((ModeW + IntW + 7) / 8) * 8;

  localparam logic [ModeW-1:0] ModeStop = 2'd0;
  localparam logic [ModeW-1:0] ModeFwd  = 2'd1;
  localparam logic [ModeW-1:0] ModeBwd  = 2'd2;

  localparam logic [MarkW-1:0] MarkUnknown = 2'd0;
  localparam logic [MarkW-1:0] MarkFwd     = 2'd1;
  localparam logic [MarkW-1:0] MarkBwd     = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHold  = 2'd2;

  localparam logic [GainW-1:0] GainRst  = 4'd1;
  localparam logic [LimW-1:0]  LimitRst = 10'd512;
  localparam logic [LimW-1:0]  HoldRst  = 10'd230;

endpackage

/* sv/integral_speed_control_hysteresis.sv */
// ----------------------------------------------------------------------------
// integral_speed_control_hysteresis
// Integral speed controller with clamp and reversal hold, one sample per cycle while m_axis accepts.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per transaction: target and measured speed.
//   m_axis returns one drive command per sample: motor mode and signed duty.
//   cfg writes gain (index 0), duty limit (index 1) and hold threshold
//   (index 2); cfg_ready_o is always high. Write only while idle.
//   A zero target clears the integral and returns stop with zero duty.
//   Samples pass through an input register, then the result register,
//   with the integrate, clamp and direction select between them.
//   Throughput is one sample per cycle while m_axis accepts, set by the
//   update of the integral and direction mark at the result register load.
//   When m_axis stalls, the result register holds and the input register
//   fills; s_axis_tready_o drops only when both are occupied.
//   Reset clears the integral and mark, loads the default registers
//   (gain 1, limit 512, hold 230) and empties both stages.
// ----------------------------------------------------------------------------
module integral_speed_control_hysteresis (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] target_speed, [31:16] measured_speed
  input  logic [iscc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] motor_mode, [12:2] duty, [15:13] zero
  output logic [iscc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iscc_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [iscc_pkg::LimW-1:0]      cfg_wdata_i
);
  import iscc_pkg::*;

  logic [GainW-1:0]            gain_q;
  logic [LimW-1:0]             lim_q;
  logic [LimW-1:0]             thr_q;

  logic                        in_valid_q;
  logic signed [SpeedBits-1:0] tgt_q;
  logic signed [SpeedBits-1:0] meas_q;

  logic                        out_valid_q;
  logic [ModeW-1:0]            out_mode_q;
  logic signed [IntW-1:0]      out_duty_q;

  logic signed [IntW-1:0]      integral_q, integral_d;
  logic [MarkW-1:0]            mark_q, mark_d;

  logic                        out_load;
  logic                        in_take;

  logic signed [DiffW-1:0]     diff;
  logic signed [ProdW-1:0]     prod;
  logic signed [AccW-1:0]      acc_raw, acc_fin, duty_fin;
  logic signed [AccW-1:0]      lim_s, thr_s;
  logic [ModeW-1:0]            mode_d;

  assign cfg_ready_o     = 1'b1;
  assign out_load        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ModeW - IntW)'(0), out_duty_q, out_mode_q};

  assign diff    = DiffW'(meas_q) - DiffW'(tgt_q);
  assign prod    = $signed({{(ProdW - GainW){1'b0}}, gain_q}) * ProdW'(diff);
  assign acc_raw = AccW'(integral_q) - AccW'(prod);
  assign lim_s   = $signed({{(AccW - LimW){1'b0}}, lim_q});
  assign thr_s   = $signed({{(AccW - LimW){1'b0}}, thr_q});

  always_comb begin
    acc_fin  = acc_raw;
    duty_fin = '0;
    mode_d   = ModeStop;
    mark_d   = mark_q;
    priority if (tgt_q == '0) begin
      acc_fin = '0;
    end else if (acc_raw > 0) begin
      if (acc_raw > lim_s) begin
        acc_fin = lim_s;
      end
      priority if (mark_q != MarkBwd) begin
        mark_d = MarkFwd;
        mode_d = ModeFwd;
      end else if (acc_fin < thr_s) begin
        acc_fin = thr_s;
        mode_d  = ModeBwd;
      end else begin
        mark_d = MarkFwd;
        mode_d = ModeFwd;
      end
      duty_fin = acc_fin;
    end else begin
      if (acc_raw < -lim_s) begin
        acc_fin = -lim_s;
      end
      priority if (mark_q != MarkFwd) begin
        mark_d   = MarkBwd;
        mode_d   = ModeBwd;
        duty_fin = -acc_fin;
      end else if (acc_fin < -thr_s) begin
        acc_fin  = -thr_s;
        mode_d   = ModeBwd;
        duty_fin = thr_s;
      end else begin
        mode_d   = ModeFwd;
        duty_fin = acc_fin;
      end
    end
  end

  assign integral_d = acc_fin[IntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainRst;
      lim_q  <= LimitRst;
      thr_q  <= HoldRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgGain:  gain_q <= cfg_wdata_i[GainW-1:0];
        CfgLimit: lim_q  <= cfg_wdata_i;
        CfgHold:  thr_q  <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      mark_q      <= MarkUnknown;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        integral_q  <= integral_d;
        mark_q      <= mark_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tgt_q  <= s_axis_tdata_i[SpeedBits-1:0];
      meas_q <= s_axis_tdata_i[2*SpeedBits-1:SpeedBits];
    end
    if (out_load) begin
      out_mode_q <= mode_d;
      out_duty_q <= duty_fin[IntW-1:0];
    end
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integral speed controller: a directed table
// (reset values, field extremes, clamp, reversal hold, zero limit, hold above
// limit, gain extremes) followed by random phases, each under a fresh register
// setting. Every sample is run through a bit-exact predictor and each drive
// command is compared by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iscc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IntW-1:0]  duty;
  } drive_t;

  typedef enum logic [1:0] {RowSample, RowWrite, RowRandom} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxW-1:0]       addr;
    logic [LimW-1:0]          wdata;
    logic signed [SpeedBits-1:0] tgt;
    logic signed [SpeedBits-1:0] meas;
    bit                       typed;
    drive_t                   want;
    int                       count;
    bit                       keep_bwd;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // [15:0] target_speed, [31:16] measured_speed
  logic [InDataW-1:0]    s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [1:0] motor_mode, [12:2] duty, [15:13] zero
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_addr_i;
  logic [LimW-1:0]       cfg_wdata_i;

  // predictor state and register copies
  longint            integ_q  = 0;
  logic [MarkW-1:0]  mark_q   = MarkUnknown;
  logic [GainW-1:0]  gain_q   = GainRst;
  logic [LimW-1:0]   limit_q  = LimitRst;
  logic [LimW-1:0]   hold_q   = HoldRst;

  drive_t pending_drive[$];
  row_t   plan[$];
  int     mismatches = 0;
  bit     calm = 1'b0;

  integral_speed_control_hysteresis u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic drive_t next_drive(logic signed [SpeedBits-1:0] tgt,
                                        logic signed [SpeedBits-1:0] meas);
    longint acc;
    longint lim;
    longint thr;
    longint duty;
    drive_t d;
    lim    = longint'(limit_q);
    thr    = longint'(hold_q);
    d.mode = ModeStop;
    d.duty = '0;
    if (tgt == 0) begin
      integ_q = 0;
      return d;
    end
    acc = integ_q - longint'(gain_q) * (longint'(meas) - longint'(tgt));
    if (acc > 0) begin
      if (acc > lim) acc = lim;
      if (mark_q != MarkBwd) begin
        mark_q = MarkFwd;
        d.mode = ModeFwd;
      end else if (acc < thr) begin
        acc    = thr;
        d.mode = ModeBwd;
      end else begin
        mark_q = MarkFwd;
        d.mode = ModeFwd;
      end
      duty = acc;
    end else begin
      if (acc < -lim) acc = -lim;
      if (mark_q != MarkFwd) begin
        mark_q = MarkBwd;
        d.mode = ModeBwd;
        duty   = -acc;
      end else if (acc < -thr) begin
        acc    = -thr;
        d.mode = ModeBwd;
        duty   = -acc;
      end else begin
        // forward with zero or negative duty
        d.mode = ModeFwd;
        duty   = acc;
      end
    end
    integ_q = acc;
    d.duty  = duty[IntW-1:0];
    return d;
  endfunction

  function automatic void add_sample(int t, int m, bit typed = 1'b0,
                                     logic [ModeW-1:0] mode = ModeStop, int duty = 0);
    row_t r;
    r.kind      = RowSample;
    r.tgt       = SpeedBits'(t);
    r.meas      = SpeedBits'(m);
    r.typed     = typed;
    r.want.mode = mode;
    r.want.duty = IntW'(duty);
    plan.push_back(r);
  endfunction

  function automatic void add_write(logic [CfgIdxW-1:0] addr, int wdata);
    row_t r;
    r.kind  = RowWrite;
    r.addr  = addr;
    r.wdata = LimW'(wdata);
    plan.push_back(r);
  endfunction

  function automatic void add_random(int count, bit keep_bwd);
    row_t r;
    r.kind     = RowRandom;
    r.count    = count;
    r.keep_bwd = keep_bwd;
    plan.push_back(r);
  endfunction

  task automatic send_sample(input logic signed [SpeedBits-1:0] tgt,
                             input logic signed [SpeedBits-1:0] meas,
                             input bit typed, input drive_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {meas, tgt};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (typed) begin
      void'(next_drive(tgt, meas));
      pending_drive.push_back(want);
    end else begin
      pending_drive.push_back(next_drive(tgt, meas));
    end
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(input logic [CfgIdxW-1:0] addr, input logic [LimW-1:0] wdata);
    s_axis_tvalid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= wdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CfgGain:  gain_q  = wdata[GainW-1:0];
      CfgLimit: limit_q = wdata;
      CfgHold:  hold_q  = wdata;
      default: ;
    endcase
  endtask

  initial begin : main
    row_t                        row;
    int                          sel;
    int                          lim;
    int                          thr;
    logic signed [SpeedBits-1:0] tgt;
    logic signed [SpeedBits-1:0] meas;
    drive_t                      none;

    none            = '0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_addr_i      <= CfgGain;
    cfg_wdata_i     <= '0;

    // backward family first: the mark never leaves forward once set
    add_sample(0, 5, 1'b1, ModeStop, 0);
    add_sample(100, 100, 1'b1, ModeBwd, 0);
    add_sample(-32768, 32767, 1'b1, ModeBwd, 512);
    add_sample(10, 0);
    add_sample(600, 0);
    add_sample(0, -32768, 1'b1, ModeStop, 0);
    add_sample(-1, -1);
    add_write(CfgGain, 10'h3FF);
    add_write(CfgLimit, 100);
    add_write(CfgHold, 1023);
    add_write(CfgSpare, 10'h2AA);
    add_sample(1, 0);
    add_sample(-1, 0);
    add_sample(-32768, 32767);
    add_write(CfgLimit, 0);
    add_sample(5, 0);
    add_sample(32767, -32768);
    // hold above limit keeps the backward mark
    add_random(80, 1'b1);
    add_write(CfgGain, 1);
    add_write(CfgLimit, 1023);
    add_write(CfgHold, 0);
    add_sample(-32768, 32767, 1'b1, ModeBwd, 1023);
    add_sample(32767, -32768, 1'b1, ModeFwd, 1023);
    add_write(CfgHold, 1023);
    add_sample(-32768, 32767, 1'b1, ModeFwd, -1023);
    add_write(CfgLimit, 512);
    add_write(CfgHold, 230);
    add_sample(1, 0);
    add_sample(1, 1);
    add_sample(200, 0);
    add_sample(100, 0);
    add_sample(0, 0, 1'b1, ModeStop, 0);
    add_sample(-32768, -32768);
    add_write(CfgGain, 0);
    add_sample(-32768, 32767);
    repeat (6) add_random(50, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        RowSample: begin
          send_sample(row.tgt, row.meas, row.typed, row.want);
        end
        RowWrite: begin
          write_reg(row.addr, row.wdata);
        end
        default: begin
          if (row.keep_bwd) begin
            lim = $urandom_range(0, 600);
            thr = $urandom_range(lim + 1, 1023);
          end else begin
            case ($urandom_range(0, 3))
              0:       lim = 1;
              1:       lim = 1023;
              default: lim = $urandom_range(1, 1023);
            endcase
            case ($urandom_range(0, 4))
              0:       thr = 0;
              1:       thr = 1023;
              default: thr = $urandom_range(0, lim);
            endcase
          end
          write_reg(CfgGain, {6'($urandom), 4'($urandom_range(0, 15))});
          write_reg(CfgLimit, LimW'(lim));
          write_reg(CfgHold, LimW'(thr));
          calm = ($urandom_range(0, 3) == 0);
          repeat (row.count) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
              tgt  = '0;
              meas = SpeedBits'($urandom);
            end else if (sel <= 2) begin
              tgt  = SpeedBits'($urandom);
              meas = SpeedBits'($urandom);
            end else begin
              // small error around a moderate target
              tgt  = SpeedBits'($urandom_range(0, 4000) - 2000);
              meas = SpeedBits'(tgt + $urandom_range(0, 400) - 200);
            end
            send_sample(tgt, meas, 1'b0, none);
          end
          calm = 1'b0;
        end
      endcase
    end

    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : drain
    int     stall;
    drive_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if (pending_drive.size() == 0) begin
        $error("unexpected transaction: motor_mode %0d duty %0d",
               m_axis_tdata_o[ModeW-1:0], $signed(m_axis_tdata_o[ModeW+IntW-1:ModeW]));
        mismatches++;
      end else begin
        want = pending_drive.pop_front();
        if (m_axis_tdata_o[ModeW-1:0] !== want.mode) begin
          $error("motor_mode: expected %0d, got %0d", want.mode, m_axis_tdata_o[ModeW-1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[ModeW+IntW-1:ModeW] !== want.duty) begin
          $error("duty: expected %0d, got %0d", $signed(want.duty),
                 $signed(m_axis_tdata_o[ModeW+IntW-1:ModeW]));
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
sv/iscc_pkg.sv
sv/integral_speed_control_hysteresis.sv
tb/sv/tb.sv
